// ===== sv/ffha_pkg.sv =====
package ffha_pkg;

  localparam int HEAP_BYTES      = 16384;
  localparam int ALIGN_BYTES     = 8;
  localparam int ALIGN_SH        = 3;
  localparam int HEADER_BYTES    = 8;
  localparam int MIN_SPLIT_BYTES = 16;
  localparam int MAX_FREE_SPANS  = 64;

  localparam int HDR_SPAN    = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int TAIL_MARK   = ((HEAP_BYTES - HDR_SPAN) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int BLOCK_SLOTS = HEAP_BYTES / ALIGN_BYTES;
  localparam int INIT_FREE   = TAIL_MARK - HDR_SPAN;

  localparam int SPAN_AW = 6;
  localparam int SLOT_AW = 11;
  localparam int CNT_W   = 7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADFREE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_FCHK,
    S_SCAN,
    S_DEC,
    S_MOVE,
    S_INS,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [14:0] request_bytes;
    logic [13:0] block_address;
  } in_t;

  typedef struct packed {
    logic        granted;
    logic [13:0] data_address;
    logic [1:0]  status;
    logic [14:0] remaining_bytes;
  } out_t;

  typedef struct packed {
    logic [13:0] start;
    logic [14:0] len;
  } span_t;

endpackage

// ===== sv/ffha_ram.sv =====
module ffha_ram #(
  parameter int DW = 16,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator. One request is handled at a time: a free-span
// table scan (one span table entry per cycle from the single read port),
// then for a full take, a two-neighbour merge or an unmerged free, a shift
// of the table tail one entry per cycle (the span table holds up to 64
// entries). After reset the block clears its 2048-entry block store, one
// entry per cycle, and accepts no request until the clear is done.
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  state_t state_r, state_nxt;

  logic [SLOT_AW-1:0] clr_idx_r, clr_idx_nxt;
  logic               kind_r, kind_nxt;
  logic [15:0]        want_r, want_nxt;
  logic [13:0]        base_r, base_nxt;
  logic [14:0]        size_r, size_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [14:0]        free_r, free_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic               found_r, found_nxt;
  span_t              cur_r, cur_nxt;
  span_t              prv_r, prv_nxt;
  logic [CNT_W-1:0]   mv_src_r, mv_src_nxt;
  logic [CNT_W-1:0]   mv_dst_r, mv_dst_nxt;
  logic [CNT_W-1:0]   mv_left_r, mv_left_nxt;
  logic               mv_up_r, mv_up_nxt;
  logic               mv_pend_r, mv_pend_nxt;
  logic               ins_r, ins_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [13:0]        res_addr_r, res_addr_nxt;
  status_t            res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               sp_we;
  logic [SPAN_AW-1:0] sp_waddr, sp_raddr;
  span_t              sp_wdata, sp_rd;
  logic               bk_we;
  logic [SLOT_AW-1:0] bk_waddr, bk_raddr;
  logic [15:0]        bk_wdata, bk_rd;

  logic               hit;
  logic [15:0]        diff;
  logic               mrg_l, mrg_r;
  logic [15:0]        req_ext;

  ffha_ram #(.DW($bits(span_t)), .AW(SPAN_AW)) u_span (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (sp_raddr),
    .rdata (sp_rd)
  );

  ffha_ram #(.DW(16), .AW(SLOT_AW)) u_blk (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (bk_raddr),
    .rdata (bk_rd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign req_ext  = {1'b0, in_data.request_bytes};
  assign bk_raddr = SLOT_AW'(in_data.block_address[13:ALIGN_SH] - 11'(HDR_SPAN >> ALIGN_SH));

  assign hit  = rd_vld_r && (kind_r ? (sp_rd.start > base_r) : ({1'b0, sp_rd.len} >= want_r));
  assign diff = {1'b0, cur_r.len} - want_r;
  assign mrg_l = (hit_idx_r != '0) &&
                 (({2'b00, prv_r.start} + {1'b0, prv_r.len}) == {2'b00, base_r});
  assign mrg_r = found_r && (({2'b00, base_r} + {1'b0, size_r}) == {2'b00, cur_r.start});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      cnt_r       <= CNT_W'(1);
      free_r      <= 15'(INIT_FREE);
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      mv_pend_r   <= 1'b0;
      ins_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      cnt_r       <= cnt_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      mv_pend_r   <= mv_pend_nxt;
      ins_r       <= ins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    want_r     <= want_nxt;
    base_r     <= base_nxt;
    size_r     <= size_nxt;
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    found_r    <= found_nxt;
    cur_r      <= cur_nxt;
    prv_r      <= prv_nxt;
    mv_src_r   <= mv_src_nxt;
    mv_dst_r   <= mv_dst_nxt;
    mv_left_r  <= mv_left_nxt;
    mv_up_r    <= mv_up_nxt;
    res_ok_r   <= res_ok_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    kind_nxt      = kind_r;
    want_nxt      = want_r;
    base_nxt      = base_r;
    size_nxt      = size_r;
    cnt_nxt       = cnt_r;
    free_nxt      = free_r;
    scan_idx_nxt  = scan_idx_r;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    hit_idx_nxt   = hit_idx_r;
    found_nxt     = found_r;
    cur_nxt       = cur_r;
    prv_nxt       = prv_r;
    mv_src_nxt    = mv_src_r;
    mv_dst_nxt    = mv_dst_r;
    mv_left_nxt   = mv_left_r;
    mv_up_nxt     = mv_up_r;
    mv_pend_nxt   = mv_pend_r;
    ins_nxt       = ins_r;
    res_ok_nxt    = res_ok_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sp_we         = 1'b0;
    sp_waddr      = '0;
    sp_wdata      = '0;
    sp_raddr      = '0;
    bk_we         = 1'b0;
    bk_waddr      = '0;
    bk_wdata      = '0;

    // drop the result once the downstream transfer completes
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        bk_we       = 1'b1;
        bk_waddr    = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == '0) begin
          sp_we    = 1'b1;
          sp_waddr = '0;
          sp_wdata = '{start: 14'(HDR_SPAN), len: 15'(INIT_FREE)};
        end
        if (&clr_idx_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          kind_nxt     = in_data.kind;
          want_nxt     = (req_ext + 16'(HDR_SPAN + ALIGN_BYTES - 1)) &
                         ~16'(ALIGN_BYTES - 1);
          base_nxt     = in_data.block_address - 14'(HDR_SPAN);
          res_ok_nxt   = 1'b0;
          res_addr_nxt = '0;
          scan_idx_nxt = '0;
          rd_vld_nxt   = 1'b0;
          if (!in_data.kind) begin
            res_st_nxt = ST_NOSPACE;
            if (in_data.request_bytes == '0 || want_nxt > {1'b0, free_r}) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            res_st_nxt = ST_BADFREE;
            if (in_data.block_address < 14'(HDR_SPAN) ||
                in_data.block_address[ALIGN_SH-1:0] != '0) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_FCHK;
            end
          end
        end
      end

      S_FCHK: begin
        size_nxt = bk_rd[14:0];
        if (bk_rd[15]) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_SCAN: begin
        if (hit) begin
          hit_idx_nxt = rd_idx_r;
          found_nxt   = 1'b1;
          cur_nxt     = sp_rd;
          rd_vld_nxt  = 1'b0;
          state_nxt   = S_DEC;
        end else begin
          if (rd_vld_r) begin
            prv_nxt = sp_rd;
          end
          if (scan_idx_r < cnt_r) begin
            sp_raddr     = scan_idx_r[SPAN_AW-1:0];
            rd_vld_nxt   = 1'b1;
            rd_idx_nxt   = scan_idx_r;
            scan_idx_nxt = scan_idx_r + 1'b1;
          end else begin
            rd_vld_nxt = 1'b0;
            if (!rd_vld_r) begin
              hit_idx_nxt = cnt_r;
              found_nxt   = 1'b0;
              state_nxt   = S_DEC;
            end
          end
        end
      end

      S_DEC: begin
        mv_pend_nxt = 1'b0;
        mv_left_nxt = '0;
        ins_nxt     = 1'b0;
        state_nxt   = S_FIN;
        if (!kind_r) begin
          if (found_r) begin
            res_ok_nxt   = 1'b1;
            res_st_nxt   = ST_OK;
            res_addr_nxt = cur_r.start + 14'(HDR_SPAN);
            bk_we        = 1'b1;
            bk_waddr     = cur_r.start[13:ALIGN_SH];
            if (diff >= 16'(MIN_SPLIT_BYTES)) begin
              sp_we    = 1'b1;
              sp_waddr = hit_idx_r[SPAN_AW-1:0];
              sp_wdata = '{start: cur_r.start + want_r[13:0], len: diff[14:0]};
              bk_wdata = {1'b1, want_r[14:0]};
              free_nxt = free_r - want_r[14:0];
            end else begin
              bk_wdata    = {1'b1, cur_r.len};
              free_nxt    = free_r - cur_r.len;
              cnt_nxt     = cnt_r - 1'b1;
              mv_up_nxt   = 1'b0;
              mv_src_nxt  = hit_idx_r + 1'b1;
              mv_left_nxt = cnt_r - 1'b1 - hit_idx_r;
              state_nxt   = S_MOVE;
            end
          end
        end else begin
          if (!mrg_l && !mrg_r && cnt_r >= CNT_W'(MAX_FREE_SPANS)) begin
            res_st_nxt = ST_FULL;
          end else begin
            res_ok_nxt = 1'b1;
            res_st_nxt = ST_OK;
            bk_we      = 1'b1;
            bk_waddr   = base_r[13:ALIGN_SH];
            bk_wdata   = '0;
            free_nxt   = free_r + size_r;
            if (mrg_l && mrg_r) begin
              sp_we       = 1'b1;
              sp_waddr    = SPAN_AW'(hit_idx_r - 1'b1);
              sp_wdata    = '{start: prv_r.start, len: prv_r.len + size_r + cur_r.len};
              cnt_nxt     = cnt_r - 1'b1;
              mv_up_nxt   = 1'b0;
              mv_src_nxt  = hit_idx_r + 1'b1;
              mv_left_nxt = cnt_r - 1'b1 - hit_idx_r;
              state_nxt   = S_MOVE;
            end else if (mrg_l) begin
              sp_we    = 1'b1;
              sp_waddr = SPAN_AW'(hit_idx_r - 1'b1);
              sp_wdata = '{start: prv_r.start, len: prv_r.len + size_r};
            end else if (mrg_r) begin
              sp_we    = 1'b1;
              sp_waddr = hit_idx_r[SPAN_AW-1:0];
              sp_wdata = '{start: base_r, len: cur_r.len + size_r};
            end else begin
              // open a gap at the insertion point, then write the new span
              cnt_nxt     = cnt_r + 1'b1;
              mv_up_nxt   = 1'b1;
              mv_src_nxt  = cnt_r - 1'b1;
              mv_left_nxt = cnt_r - hit_idx_r;
              ins_nxt     = 1'b1;
              state_nxt   = S_MOVE;
            end
          end
        end
      end

      S_MOVE: begin
        if (mv_pend_r) begin
          sp_we    = 1'b1;
          sp_waddr = mv_dst_r[SPAN_AW-1:0];
          sp_wdata = sp_rd;
        end
        if (mv_left_r != '0) begin
          sp_raddr    = mv_src_r[SPAN_AW-1:0];
          mv_pend_nxt = 1'b1;
          mv_dst_nxt  = mv_up_r ? mv_src_r + 1'b1 : mv_src_r - 1'b1;
          mv_src_nxt  = mv_up_r ? mv_src_r - 1'b1 : mv_src_r + 1'b1;
          mv_left_nxt = mv_left_r - 1'b1;
        end else begin
          mv_pend_nxt = 1'b0;
          if (!mv_pend_r) begin
            state_nxt = ins_r ? S_INS : S_FIN;
          end
        end
      end

      S_INS: begin
        sp_we     = 1'b1;
        sp_waddr  = hit_idx_r[SPAN_AW-1:0];
        sp_wdata  = '{start: base_r, len: size_r};
        ins_nxt   = 1'b0;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{granted: res_ok_r, data_address: res_addr_r,
                            status: res_st_r, remaining_bytes: free_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FREE_SPANS))
    else $error("span count beyond table size");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= 15'(INIT_FREE))
    else $error("free byte count beyond heap");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.granted |-> out_data.status == ST_OK)
    else $error("grant with failure status");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.granted |-> out_data.data_address == '0)
    else $error("address on failed request");
`endif

endmodule
